FILE: sv/aid_pkg.sv
`timescale 1ns / 1ps
// Package for the array insert/delete unit: sizes, action and status codes,
// and the per-cell operation code. Used by aid_cell and array_insert_delete_unit.
package aid_pkg;

   localparam int DEPTH   = 32;
   localparam int WORD_W  = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int POS_W   = 6;
   localparam int COUNT_W = 6;
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // What a cell loads at the next edge.
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LOWER = 2'd2,
      CELL_FROM_UPPER = 2'd3
   } cell_op_type;

endpackage

FILE: sv/array_insert_delete_unit.sv
`timescale 1ns / 1ps
// Top level of the array insert/delete unit: a chain of aid_cell storage cells
// with the count, status decode and a registered response. Depends on aid_pkg and aid_cell.

// The unit keeps a packed, ordered array of up to DEPTH signed 32-bit words
// and a count of how many are held. Each request carries an action: insert
// places the value at a 0-based position and moves the words at and above it
// up by one; delete removes the lowest-placed word equal to the value and
// moves the words above it down by one; read returns the word at a position.
// Every request gives exactly one response with a status (ok, position out of
// range, array full, value not found), the word read (zero unless a read
// succeeds) and the count after the action. A failed request leaves the array
// unchanged, and the unused action code is answered with ok and no change.
// Each word sits in its own cell, and all cells compare against the request
// value and move to their neighbor in the same cycle, so the response of a
// request appears in the output register at the edge that accepts it, and a
// new request can be accepted in every cycle unless stalled. The response
// register is the only buffer, so a request is stalled only while a finished
// response waits on a stalled response channel. There is no clearing pass
// after reset: only words below the count are ever visible.
module array_insert_delete_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic signed [aid_pkg::WORD_W-1:0] req_value,
   input  logic [aid_pkg::POS_W-1:0]         req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic signed [aid_pkg::WORD_W-1:0] rsp_read_value,
   output logic [aid_pkg::COUNT_W-1:0]       rsp_count
);

   localparam int DEPTH = aid_pkg::DEPTH;

   logic                          req_accept;
   logic [aid_pkg::CNT_W-1:0]     count_ff;
   logic [aid_pkg::CNT_W-1:0]     count_in;
   logic [aid_pkg::CMP_W-1:0]     count_ext;
   logic [aid_pkg::CMP_W-1:0]     pos_ext;

   logic [aid_pkg::WORD_W-1:0]    cell_word [DEPTH];
   logic [DEPTH-1:0]              cell_match;
   logic [DEPTH-1:0]              live_match;
   logic [DEPTH-1:0]              below_match;
   aid_pkg::cell_op_type          cell_op [DEPTH];

   logic                          do_insert;
   logic                          do_delete;
   aid_pkg::status_type           rsp_status_in;
   logic [aid_pkg::WORD_W-1:0]    rsp_read_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   aid_pkg::status_type           rsp_status_ff;
   logic [aid_pkg::WORD_W-1:0]    rsp_read_ff;
   logic [aid_pkg::COUNT_W-1:0]   rsp_count_ff;

   // The single response register frees up whenever it is empty or drained.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign count_ext = aid_pkg::CMP_W'(count_ff);
   assign pos_ext   = aid_pkg::CMP_W'(req_position);

   // Only cells below the count take part in the search.
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         live_match[k] = cell_match[k] && (aid_pkg::CMP_W'(k) < count_ext);
      end
   end

   // Bits strictly below the lowest match; all ones when nothing matches.
   assign below_match = (live_match - DEPTH'(1)) & ~live_match;

   // Decode the request into a status, a read word and the new count.
   always_comb begin
      rsp_status_in = aid_pkg::ST_OK;
      rsp_read_in   = '0;
      do_insert     = 1'b0;
      do_delete     = 1'b0;
      count_in      = count_ff;
      unique case (req_action)
         aid_pkg::ACT_INSERT: begin
            if (pos_ext > count_ext) begin
               rsp_status_in = aid_pkg::ST_BAD_POS;
            end else if (count_ff == aid_pkg::CNT_W'(DEPTH)) begin
               rsp_status_in = aid_pkg::ST_FULL;
            end else begin
               do_insert = req_accept;
               count_in  = aid_pkg::CNT_W'(count_ff + 1'b1);
            end
         end
         aid_pkg::ACT_DELETE: begin
            if (live_match == '0) begin
               rsp_status_in = aid_pkg::ST_NOT_FOUND;
            end else begin
               do_delete = req_accept;
               count_in  = aid_pkg::CNT_W'(count_ff - 1'b1);
            end
         end
         aid_pkg::ACT_READ: begin
            if (pos_ext < count_ext) begin
               rsp_read_in = cell_word[req_position[aid_pkg::IDX_W-1:0]];
            end else begin
               rsp_status_in = aid_pkg::ST_BAD_POS;
            end
         end
         default: begin
            rsp_status_in = aid_pkg::ST_OK;
         end
      endcase
   end

   // The chain of cells. An insert moves the cells above the position up by
   // one and loads the value at the position; a delete pulls every cell from
   // the first match upward down by one.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [aid_pkg::WORD_W-1:0] lower_word;
      logic [aid_pkg::WORD_W-1:0] upper_word;

      if (k == 0) begin : g_first
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = cell_word[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign upper_word = cell_word[k];
      end else begin : g_upper
         assign upper_word = cell_word[k+1];
      end

      always_comb begin
         cell_op[k] = aid_pkg::CELL_HOLD;
         if (do_insert) begin
            if (aid_pkg::CMP_W'(k) == pos_ext) begin
               cell_op[k] = aid_pkg::CELL_LOAD;
            end else if (aid_pkg::CMP_W'(k) > pos_ext) begin
               cell_op[k] = aid_pkg::CELL_FROM_LOWER;
            end
         end else if (do_delete) begin
            if (!below_match[k]) begin
               cell_op[k] = aid_pkg::CELL_FROM_UPPER;
            end
         end
      end

      aid_cell u_cell (
         .clock      (clock),
         .op         (cell_op[k]),
         .new_word   (req_value),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word       (cell_word[k]),
         .match      (cell_match[k])
      );
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_count_ff  <= aid_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_count      = rsp_count_ff;

`ifndef SYNTH
   // The count never grows past the array size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= aid_pkg::CNT_W'(DEPTH))
      else $error("entry count exceeds array size");

   // A successful insert adds exactly one word.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_action == aid_pkg::ACT_INSERT && rsp_status_in == aid_pkg::ST_OK
      |=> count_ff == aid_pkg::CNT_W'($past(count_ff) + 1'b1))
      else $error("insert did not add one entry");

   // A delete that finds nothing leaves the count alone.
   a_miss_stable: assert property (@(posedge clock) disable iff (reset)
      req_accept && rsp_status_in == aid_pkg::ST_NOT_FOUND |=> $stable(count_ff))
      else $error("count changed on a failed delete");

   // The response carries the count that the array holds afterward.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_count_ff == aid_pkg::COUNT_W'(count_ff))
      else $error("response count does not match stored count");
`endif

endmodule

FILE: sv/aid_cell.sv
`timescale 1ns / 1ps
// One storage cell of the array chain: holds a word, compares it with the
// request value and takes a new word from the request or a neighbor.
// Depends on aid_pkg.
module aid_cell (
   input  logic                       clock,
   input  aid_pkg::cell_op_type       op,
   input  logic [aid_pkg::WORD_W-1:0] new_word,
   input  logic [aid_pkg::WORD_W-1:0] lower_word,
   input  logic [aid_pkg::WORD_W-1:0] upper_word,
   output logic [aid_pkg::WORD_W-1:0] word,
   output logic                       match
);

   logic [aid_pkg::WORD_W-1:0] word_ff;
   logic [aid_pkg::WORD_W-1:0] word_in;

   always_comb begin
      unique case (op)
         aid_pkg::CELL_LOAD:       word_in = new_word;
         aid_pkg::CELL_FROM_LOWER: word_in = lower_word;
         aid_pkg::CELL_FROM_UPPER: word_in = upper_word;
         default:                  word_in = word_ff;
      endcase
   end

   // Stored words need no reset; the count decides which are meaningful.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = (word_ff == new_word);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_insert_delete_unit: a scoreboard class predicts each
// response, and plain tasks drive requests and response back-pressure. Depends on aid_pkg.

module testbench;

   // The block decodes only three action codes. The fourth is sent on purpose and must be
   // answered with ok and no change.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int WORD_MIN   = 32'sh8000_0000;
   localparam int WORD_MAX   = 32'sh7fff_ffff;
   localparam int POS_MAX    = (1 << aid_pkg::POS_W) - 1;
   localparam int MAX_GAP    = 13;
   localparam int PHASE_LEN  = 50;
   localparam int NUM_PHASES = 11;
   localparam int LONG_HOLD  = 90;
   localparam int TAIL       = 10;

   // Kinds of random traffic. Each phase of the random part uses one kind.
   localparam int MIX_GROW   = 0;
   localparam int MIX_SHRINK = 1;
   localparam int MIX_NOISY  = 2;
   localparam int MIX_FILL   = 3;

   typedef struct packed {
      logic [1:0]                        action;
      logic signed [aid_pkg::WORD_W-1:0] value;
      logic [aid_pkg::POS_W-1:0]         position;
   } request_type;

   typedef struct packed {
      aid_pkg::status_type               status;
      logic signed [aid_pkg::WORD_W-1:0] read_value;
      logic [aid_pkg::COUNT_W-1:0]       count;
   } answer_type;

   // The scoreboard keeps its own copy of the array and the count. Each accepted request
   // updates that copy and queues the answer that the block must give. Each accepted
   // response is compared with the oldest queued answer.
   class array_scoreboard;
      logic signed [aid_pkg::WORD_W-1:0] words [aid_pkg::DEPTH];
      int held;
      int peak;
      int fails;
      int answered;
      int by_action [4];
      int by_status [4];
      answer_type answer_q [$];

      // One line for each mismatch, and a count of them all.
      task report(string what);
         fails++;
         $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      function void note_request(request_type r);
         answer_type a;
         int hit;
         a.status = aid_pkg::ST_OK;
         a.read_value = '0;
         hit = -1;
         case (r.action)
            aid_pkg::ACT_INSERT: begin
               // A position beyond the count is refused before fullness is looked at.
               if (r.position > held)
                  a.status = aid_pkg::ST_BAD_POS;
               else if (held >= aid_pkg::DEPTH)
                  a.status = aid_pkg::ST_FULL;
               else begin
                  for (int k = held; k > r.position; k--)
                     words[k] = words[k - 1];
                  words[r.position] = r.value;
                  held++;
               end
            end
            aid_pkg::ACT_DELETE: begin
               // The search covers every held word, the last one included.
               for (int k = 0; k < held; k++)
                  if (hit < 0 && words[k] == r.value)
                     hit = k;
               if (hit < 0)
                  a.status = aid_pkg::ST_NOT_FOUND;
               else begin
                  for (int k = hit; k < held - 1; k++)
                     words[k] = words[k + 1];
                  held--;
               end
            end
            aid_pkg::ACT_READ: begin
               if (r.position < held)
                  a.read_value = words[r.position];
               else
                  a.status = aid_pkg::ST_BAD_POS;
            end
            default: ;
         endcase
         if (held > peak)
            peak = held;
         a.count = aid_pkg::COUNT_W'(held);
         by_action[r.action]++;
         by_status[a.status]++;
         answer_q.push_back(a);
      endfunction

      task check(logic [1:0] status, logic signed [aid_pkg::WORD_W-1:0] read_value,
                 logic [aid_pkg::COUNT_W-1:0] count);
         answer_type a;
         if (answer_q.size() == 0)
            report($sformatf("response with no request outstanding (status %0d, count %0d)",
                             status, count));
         else begin
            a = answer_q.pop_front();
            answered++;
            if (status !== a.status)
               report($sformatf("response %0d: status %0d, expected %0d",
                                answered, status, a.status));
            if (read_value !== a.read_value)
               report($sformatf("response %0d: read value %0d, expected %0d",
                                answered, read_value, a.read_value));
            if (count !== a.count)
               report($sformatf("response %0d: count %0d, expected %0d",
                                answered, count, a.count));
         end
      endtask

      function int outstanding();
         return answer_q.size();
      endfunction
   endclass

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic [1:0]                        req_action     = aid_pkg::ACT_INSERT;
   logic signed [aid_pkg::WORD_W-1:0] req_value      = '0;
   logic [aid_pkg::POS_W-1:0]         req_position   = '0;
   logic                              rsp_stall      = 1'b0;
   logic                              req_stall;
   logic                              rsp_valid;
   logic [1:0]                        rsp_status;
   logic signed [aid_pkg::WORD_W-1:0] rsp_read_value;
   logic [aid_pkg::COUNT_W-1:0]       rsp_count;

   array_scoreboard sb = new();

   // Idling switches for the two sides, set per phase by the main sequence. A hold
   // request asks the response side for one long stall, which it counts out itself.
   bit tx_idle       = 1'b0;
   bit rx_idle       = 1'b0;
   int rx_hold_cycles = 0;

   array_insert_delete_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The slowest correct run is about 600 requests, plus the long hold and the drain
   // pauses. Two milliseconds leaves a wide margin.
   initial begin
      #2_000_000;
      $display("Timeout with %0d responses still outstanding.", sb.outstanding());
      $display("** array_insert_delete_unit: FAILED **");
      $finish;
   end

   // Responses are taken at each edge where valid is high and the stall is low. Values
   // are sampled before any update of this edge takes effect, so the check does not
   // depend on the order of processes within the time step.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check(rsp_status, rsp_read_value, rsp_count);
   end

   // Response side. Before each response it draws a random stall, possibly none, when
   // idling is on for the phase, or takes the long hold when one has been asked for. The
   // stall is then lowered and held low until a response is taken.
   initial begin : response_side
      int wait_cycles;
      @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            wait_cycles = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else
            wait_cycles = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offers one request, after a random gap when idling is on. The task returns in the
   // time step of the edge that accepted the request, with valid still high, so that a
   // following request with no gap goes out back to back. The prediction is made at
   // that point, in the order in which the block accepts requests.
   task automatic offer(input request_type r);
      int gap;
      gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= r.action;
      req_value    <= r.value;
      req_position <= r.position;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
   endtask

   // Lowers valid and waits until every outstanding response has come back. It always
   // waits on a clock edge first, so valid is never written twice in one time step.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic request_type req(logic [1:0] action, int value, int position);
      request_type r;
      r.action = action;
      r.value = value;
      r.position = aid_pkg::POS_W'(position);
      return r;
   endfunction

   // Values lean toward a small pool and toward words already held, so that deletes
   // find matches and duplicates occur. The extremes of the word come up often too.
   function automatic int pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return WORD_MIN;
      else if (roll == 1)
         return WORD_MAX;
      else if (roll < 5)
         return int'($urandom_range(0, 7)) - 4;
      else if (roll < 7 && sb.held > 0)
         return sb.words[$urandom_range(0, sb.held - 1)];
      else
         return $urandom;
   endfunction

   // Builds one random request. Most are well formed: inserts at a position up to the
   // count, deletes of a held word, reads below the count. The rest are noise with any
   // action code, any word and any position.
   function automatic request_type make_request(int mix);
      request_type r;
      int roll;
      int ins_top;
      int del_top;
      int rd_top;
      case (mix)
         MIX_GROW: begin
            ins_top = 7; del_top = 8; rd_top = 9;
         end
         MIX_SHRINK: begin
            ins_top = 2; del_top = 7; rd_top = 9;
         end
         default: begin
            ins_top = 3; del_top = 6; rd_top = 8;
         end
      endcase
      roll = $urandom_range(0, 9);
      r = req(aid_pkg::ACT_INSERT, pick_value(), $urandom_range(0, sb.held));
      if (roll < ins_top)
         ;
      else if (roll < del_top) begin
         r.action = aid_pkg::ACT_DELETE;
         if (sb.held > 0 && $urandom_range(0, 3) != 0)
            r.value = sb.words[$urandom_range(0, sb.held - 1)];
      end else if (roll < rd_top) begin
         r.action = aid_pkg::ACT_READ;
         if (sb.held > 0 && $urandom_range(0, 3) != 0)
            r.position = aid_pkg::POS_W'($urandom_range(0, sb.held - 1));
         else
            r.position = aid_pkg::POS_W'($urandom_range(0, POS_MAX));
      end else
         r = req(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, POS_MAX));
      return r;
   endfunction

   // Short hand-picked sequence: the empty array, inserts at the front, middle and end,
   // positions just past and far past the count, duplicates where delete must take the
   // lower one, delete of the last word, a failed search, and the unused action code.
   task automatic directed_requests();
      offer(req(aid_pkg::ACT_READ,   0,        0));        // read of an empty array
      offer(req(aid_pkg::ACT_DELETE, 7,        0));        // search of an empty array
      offer(req(aid_pkg::ACT_INSERT, 9,        1));        // position just past the count
      offer(req(aid_pkg::ACT_INSERT, WORD_MIN, 0));
      offer(req(aid_pkg::ACT_INSERT, WORD_MAX, 1));        // append at the count
      offer(req(aid_pkg::ACT_INSERT, -1,       0));        // front, moves both up
      offer(req(aid_pkg::ACT_INSERT, 5,        1));        // middle
      offer(req(aid_pkg::ACT_INSERT, 5,        4));        // append a duplicate
      offer(req(aid_pkg::ACT_INSERT, 3,        POS_MAX));  // every position bit set
      offer(req(aid_pkg::ACT_INSERT, 3,        6));
      for (int k = 0; k < 5; k++)
         offer(req(aid_pkg::ACT_READ, 0, k));
      offer(req(aid_pkg::ACT_READ,   0,        5));        // read at the count
      offer(req(aid_pkg::ACT_READ,   0,        POS_MAX));
      offer(req(aid_pkg::ACT_DELETE, 5,        0));        // lower copy goes first
      offer(req(aid_pkg::ACT_READ,   0,        3));        // upper copy is still there
      offer(req(aid_pkg::ACT_DELETE, 5,        0));        // now the last word
      offer(req(aid_pkg::ACT_DELETE, WORD_MAX, 0));        // last word again
      offer(req(aid_pkg::ACT_DELETE, 1234,     0));        // no match
      offer(req(ACT_UNUSED,          -1,       POS_MAX));  // unused code, all bits set
      offer(req(aid_pkg::ACT_DELETE, -1,       0));
      offer(req(aid_pkg::ACT_READ,   0,        0));
   endtask

   // Fills the array with random words at random legal positions, then probes it while
   // full: the full refusal, the bad-position refusal that takes precedence over it,
   // reads at the top, and removal of the top word followed by a refill.
   task automatic fill_and_probe();
      while (sb.held < aid_pkg::DEPTH)
         offer(req(aid_pkg::ACT_INSERT, $urandom, $urandom_range(0, sb.held)));
      offer(req(aid_pkg::ACT_INSERT, pick_value(), aid_pkg::DEPTH));
      offer(req(aid_pkg::ACT_INSERT, pick_value(), aid_pkg::DEPTH + 1));
      offer(req(aid_pkg::ACT_INSERT, pick_value(), 0));
      offer(req(aid_pkg::ACT_READ,   0,            aid_pkg::DEPTH - 1));
      offer(req(aid_pkg::ACT_READ,   0,            aid_pkg::DEPTH));
      offer(req(aid_pkg::ACT_DELETE, sb.words[aid_pkg::DEPTH - 1], 0));
      offer(req(aid_pkg::ACT_INSERT, WORD_MIN,     aid_pkg::DEPTH - 1));
      offer(req(aid_pkg::ACT_READ,   0,            aid_pkg::DEPTH - 1));
      repeat (PHASE_LEN / 2)
         offer(make_request(MIX_NOISY));
   endtask

   initial begin : main_sequence
      int mix;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      directed_requests();

      // Random part. The first phases take the kinds in order, so the array grows,
      // shrinks, and is driven full at least once; the rest pick at random. Phase 0 runs
      // with no idling on either side. In phase 1 the response side holds off for a long
      // stretch while requests keep coming, so the response register fills and the
      // block stalls its input. Before phase 2, and at random before any other phase,
      // the request side waits until every response is back.
      for (int p = 0; p < NUM_PHASES; p++) begin
         mix = (p <= MIX_FILL) ? p : $urandom_range(MIX_GROW, MIX_FILL);
         tx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
         rx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
         if (p == 1)
            rx_hold_cycles = LONG_HOLD;
         if (p == 2 || $urandom_range(0, 3) == 0)
            drain();
         if (mix == MIX_FILL)
            fill_and_probe();
         else
            repeat (PHASE_LEN)
               offer(make_request(mix));
      end

      drain();
      repeat (TAIL) @(posedge clock);

      $display("Checked %0d responses: %0d insert, %0d delete, %0d read, %0d unused code.",
               sb.answered, sb.by_action[aid_pkg::ACT_INSERT],
               sb.by_action[aid_pkg::ACT_DELETE], sb.by_action[aid_pkg::ACT_READ],
               sb.by_action[ACT_UNUSED]);
      $display("Outcomes: %0d ok, %0d bad position, %0d full, %0d not found; peak count %0d.",
               sb.by_status[aid_pkg::ST_OK], sb.by_status[aid_pkg::ST_BAD_POS],
               sb.by_status[aid_pkg::ST_FULL], sb.by_status[aid_pkg::ST_NOT_FOUND], sb.peak);
      if (sb.fails == 0 && sb.outstanding() == 0)
         $display("** array_insert_delete_unit: PASSED **");
      else
         $display("** array_insert_delete_unit: FAILED **");
      $finish;
   end

endmodule

FILE: array_insert_delete_unit.f
sv/aid_pkg.sv
sv/aid_cell.sv
sv/array_insert_delete_unit.sv
verif/testbench.sv
